/* rtl/core/bels_pkg.sv */
// ----------------------------------------------------------------------------
// bels_pkg
// Shared types, class codes and helpers of the explicit bidi level stack.
// ----------------------------------------------------------------------------
package bels_pkg;

  localparam int unsigned STACK_DEPTH = 127;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned OVF_BITS    = 16;
  localparam int unsigned VALID_W     = 7;

  localparam logic [VALID_W-1:0] VALID_MAX = '1;

  localparam logic [4:0] CL_L   = 5'd0;
  localparam logic [4:0] CL_R   = 5'd1;
  localparam logic [4:0] CL_BN  = 5'd9;
  localparam logic [4:0] CL_B   = 5'd10;
  localparam logic [4:0] CL_LRE = 5'd14;
  localparam logic [4:0] CL_LRO = 5'd15;
  localparam logic [4:0] CL_RLE = 5'd16;
  localparam logic [4:0] CL_RLO = 5'd17;
  localparam logic [4:0] CL_PDF = 5'd18;
  localparam logic [4:0] CL_LRI = 5'd19;
  localparam logic [4:0] CL_RLI = 5'd20;
  localparam logic [4:0] CL_FSI = 5'd21;
  localparam logic [4:0] CL_PDI = 5'd22;

  localparam logic [1:0] OVR_NONE = 2'd0;
  localparam logic [1:0] OVR_LTR  = 2'd1;
  localparam logic [1:0] OVR_RTL  = 2'd2;

  // The isolate position is one above the index of the nearest isolate entry
  // at or below this entry, or zero when there is none.
  typedef struct packed {
    logic [CNT_W-1:0] iso_pos;
    logic             iso;
    logic [1:0]       ovr;
    logic [7:0]       level;
  } entry_t;

  typedef struct packed {
    logic load;
    logic start;
    logic exec;
    logic land;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic start_req;
    logic drop;
    logic fetch;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] next_level(input logic [7:0] lvl, input logic odd);
    logic [7:0] n;
    n = lvl + 8'd1;
    if (n[0] != odd) n = n + 8'd1;
    return n;
  endfunction

  function automatic logic [4:0] apply_ovr(input logic [4:0] cls, input logic [1:0] ovr);
    logic [4:0] r;
    r = cls;
    if (ovr == OVR_LTR) r = CL_L;
    else if (ovr == OVR_RTL) r = CL_R;
    return r;
  endfunction

endpackage

/* rtl/core/bidi_explicit_level_stack.sv */
// ----------------------------------------------------------------------------
// bidi_explicit_level_stack
// Explicit embedding levels (bidi rules X1 to X8), one character per beat.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o  code_point, char_class, fsi_rtl,
//                                                start_paragraph, base_level,
//                                                last_in_paragraph
//   out      output     out_valid_o / out_ready_i out_code_point, out_class, level
//
// A character passes through load, execute and emit, plus a start step when it
// starts a paragraph and a landing step when a pop leaves a new top that is read
// back from the stack memory. A final FSI produces no beat and ends after execute.
// The next character is accepted while a result waits in the output register.
// Reset clears the stack count and counters; the stack memory is not cleared.
// ----------------------------------------------------------------------------
module bidi_explicit_level_stack (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [20:0] code_point_i,
  input  logic [4:0]  char_class_i,
  input  logic        fsi_rtl_i,
  input  logic        start_paragraph_i,
  input  logic        base_level_i,
  input  logic        last_in_paragraph_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] out_code_point_o,
  output logic [4:0]  out_class_o,
  output logic [7:0]  level_o
);

  bels_pkg::cmd_t cmd;
  bels_pkg::sts_t sts;

  bels_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bels_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .code_point_i        (code_point_i),
    .char_class_i        (char_class_i),
    .fsi_rtl_i           (fsi_rtl_i),
    .start_paragraph_i   (start_paragraph_i),
    .base_level_i        (base_level_i),
    .last_in_paragraph_i (last_in_paragraph_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_code_point_o    (out_code_point_o),
    .out_class_o         (out_class_o),
    .level_o             (level_o)
  );

endmodule

/* rtl/core/bels_ctrl.sv */
// ----------------------------------------------------------------------------
// bels_ctrl
// Sequencer: load, optional paragraph start, execute, optional stack landing, emit.
// ----------------------------------------------------------------------------
module bels_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bels_pkg::sts_t sts_i,
  output bels_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_LAND  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.start_req ? S_START : S_EXEC;
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.drop) state_d = S_IDLE;
        else if (sts_i.fetch) state_d = S_LAND;
        else state_d = S_EMIT;
      end
      S_LAND: begin
        cmd_o.land = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/bels_dp.sv */
// ----------------------------------------------------------------------------
// bels_dp
// Datapath: status stack memory, cached top entry, counters, output register.
// ----------------------------------------------------------------------------
module bels_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bels_pkg::cmd_t cmd_i,
  output bels_pkg::sts_t sts_o,
  input  logic [20:0]    code_point_i,
  input  logic [4:0]     char_class_i,
  input  logic           fsi_rtl_i,
  input  logic           start_paragraph_i,
  input  logic           base_level_i,
  input  logic           last_in_paragraph_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [20:0]    out_code_point_o,
  output logic [4:0]     out_class_o,
  output logic [7:0]     level_o
);

  localparam int unsigned CNT_W  = bels_pkg::CNT_W;
  localparam int unsigned ADDR_W = bels_pkg::ADDR_W;
  localparam int unsigned OVF_W  = bels_pkg::OVF_BITS;
  localparam int unsigned VAL_W  = bels_pkg::VALID_W;

  bels_pkg::entry_t mem_q [bels_pkg::STACK_DEPTH];

  logic [20:0] cp_q;
  logic [4:0]  cls_q;
  logic        fsi_rtl_q, base_q, last_q;

  logic [CNT_W-1:0] count_q, count_d, pend_q, pend_d;
  logic [OVF_W-1:0] oi_q, oi_d, oe_q, oe_d;
  logic [VAL_W-1:0] vi_q, vi_d;
  bels_pkg::entry_t top_q, top_d, rd_q, top_eff;

  logic [4:0] pre_cls_q;
  logic [7:0] pre_lvl_q;

  logic        out_valid_q, out_valid_d;
  logic [20:0] out_cp_q;
  logic [4:0]  out_cls_q;
  logic [7:0]  out_lvl_q;

  logic is_embed, is_iso, drop, odd_emb, odd_iso, room;
  logic keep_cls, push, pop, fetch;
  logic [1:0] ovr_emb;
  logic [CNT_W-1:0] pop_cnt;
  bels_pkg::entry_t push_ent;
  logic [OVF_W-1:0] oi_x, oe_x;
  logic [VAL_W-1:0] vi_x;

  logic             wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  bels_pkg::entry_t  wr_data;

  logic [4:0] res_cls;

  assign top_eff = (count_q == '0) ? '0 : top_q;
  assign room    = count_q < CNT_W'(bels_pkg::STACK_DEPTH);

  assign is_embed = (cls_q == bels_pkg::CL_RLE) || (cls_q == bels_pkg::CL_LRE) ||
                    (cls_q == bels_pkg::CL_RLO) || (cls_q == bels_pkg::CL_LRO);
  assign is_iso   = (cls_q == bels_pkg::CL_RLI) || (cls_q == bels_pkg::CL_LRI) ||
                    (cls_q == bels_pkg::CL_FSI);
  assign drop     = (cls_q == bels_pkg::CL_FSI) && last_q;
  assign odd_emb  = (cls_q == bels_pkg::CL_RLE) || (cls_q == bels_pkg::CL_RLO);
  assign odd_iso  = (cls_q == bels_pkg::CL_RLI) || ((cls_q == bels_pkg::CL_FSI) && fsi_rtl_q);
  assign ovr_emb  = (cls_q == bels_pkg::CL_RLO) ? bels_pkg::OVR_RTL :
                    (cls_q == bels_pkg::CL_LRO) ? bels_pkg::OVR_LTR : bels_pkg::OVR_NONE;

  // Decode of one character against the current stack top and counters.
  always_comb begin
    push     = 1'b0;
    pop      = 1'b0;
    pop_cnt  = count_q;
    oi_x     = oi_q;
    oe_x     = oe_q;
    vi_x     = vi_q;
    push_ent = '{iso_pos: top_eff.iso_pos, iso: 1'b0, ovr: ovr_emb,
                 level: bels_pkg::next_level(top_eff.level, odd_emb)};
    if (is_embed) begin
      if (oi_q == '0) begin
        if (oe_q == '0 && room) push = 1'b1;
        else if (oe_q != '1) oe_x = oe_q + 1'b1;
      end
    end else if (is_iso) begin
      push_ent = '{iso_pos: count_q + 1'b1, iso: 1'b1, ovr: bels_pkg::OVR_NONE,
                   level: bels_pkg::next_level(top_eff.level, odd_iso)};
      if (!drop) begin
        if (oi_q == '0 && oe_q == '0 && room) begin
          push = 1'b1;
          if (vi_q != bels_pkg::VALID_MAX) vi_x = vi_q + 1'b1;
        end else if (oi_q != '1) begin
          oi_x = oi_q + 1'b1;
        end
      end
    end else if (cls_q == bels_pkg::CL_PDI) begin
      if (oi_q != '0) begin
        oi_x = oi_q - 1'b1;
      end else if (vi_q != '0) begin
        oe_x    = '0;
        pop     = 1'b1;
        pop_cnt = top_eff.iso_pos - 1'b1;
        vi_x    = vi_q - 1'b1;
      end
    end else if (cls_q == bels_pkg::CL_PDF) begin
      if (oi_q == '0) begin
        if (oe_q != '0) begin
          oe_x = oe_q - 1'b1;
        end else if (count_q >= CNT_W'(2) && !top_eff.iso) begin
          pop     = 1'b1;
          pop_cnt = count_q - 1'b1;
        end
      end
    end else if (cls_q == bels_pkg::CL_B) begin
      if (count_q > CNT_W'(1)) begin
        pop     = 1'b1;
        pop_cnt = CNT_W'(1);
      end
      oi_x = '0;
      oe_x = '0;
      vi_x = '0;
    end
  end

  assign fetch   = pop && (pop_cnt != '0);
  assign rd_addr = ADDR_W'(pop_cnt - 1'b1);
  assign rd_en   = cmd_i.exec && fetch;

  assign sts_o.start_req = start_paragraph_i;
  assign sts_o.drop      = drop;
  assign sts_o.fetch     = fetch;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    count_d     = count_q;
    pend_d      = pend_q;
    top_d       = top_q;
    oi_d        = oi_q;
    oe_d        = oe_q;
    vi_d        = vi_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[ADDR_W-1:0];
    wr_data     = push_ent;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.start) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '{iso_pos: '0, iso: 1'b0, ovr: bels_pkg::OVR_NONE, level: {7'd0, base_q}};
      top_d   = wr_data;
      count_d = CNT_W'(1);
      oi_d    = '0;
      oe_d    = '0;
      vi_d    = '0;
    end
    if (cmd_i.exec) begin
      oi_d = oi_x;
      oe_d = oe_x;
      vi_d = vi_x;
      if (push) begin
        wr_en   = 1'b1;
        top_d   = push_ent;
        count_d = count_q + 1'b1;
      end
      if (pop) begin
        if (fetch) pend_d = pop_cnt;
        else count_d = pop_cnt;
      end
    end
    if (cmd_i.land) begin
      count_d = pend_q;
      top_d   = rd_q;
    end
    if (cmd_i.emit) out_valid_d = 1'b1;
  end

  assign keep_cls = (cls_q == bels_pkg::CL_RLE) || (cls_q == bels_pkg::CL_LRE) ||
                    (cls_q == bels_pkg::CL_RLO) || (cls_q == bels_pkg::CL_PDF) ||
                    (cls_q == bels_pkg::CL_B)   || (cls_q == bels_pkg::CL_BN);
  assign res_cls  = keep_cls ? cls_q : bels_pkg::apply_ovr(cls_q, top_eff.ovr);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cp_q      <= code_point_i;
      cls_q     <= char_class_i;
      fsi_rtl_q <= fsi_rtl_i;
      base_q    <= base_level_i;
      last_q    <= last_in_paragraph_i;
    end
    if (cmd_i.exec) begin
      pre_cls_q <= bels_pkg::apply_ovr(cls_q, top_eff.ovr);
      pre_lvl_q <= top_eff.level;
    end
    if (cmd_i.emit) begin
      out_cp_q  <= cp_q;
      out_cls_q <= is_iso ? pre_cls_q : res_cls;
      out_lvl_q <= is_iso ? pre_lvl_q : top_eff.level;
    end
    top_q  <= top_d;
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      oi_q        <= '0;
      oe_q        <= '0;
      vi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      oi_q        <= oi_d;
      oe_q        <= oe_d;
      vi_q        <= vi_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_code_point_o = out_cp_q;
  assign out_class_o      = out_cls_q;
  assign level_o          = out_lvl_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(bels_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_iso_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> top_q.iso_pos <= count_q)
    else $error("isolate link points above the stack top");

  a_iso_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vi_q != '0 |-> (count_q != '0 && top_q.iso_pos != '0))
    else $error("valid isolates counted with no isolate entry on the stack");

  a_land: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.land |=> (count_q == $past(pend_q) && top_q == $past(rd_q)))
    else $error("stack top not reloaded after pop");

endmodule
